// File: sv/hclsrch_pkg.sv
// Package for the hash code line search block: widths, request codes and the
// search request struct handed from the top level to the match logic.
// No dependencies.
`timescale 1ns / 1ps

package hclsrch_pkg;

  localparam int CODE_W      = 16;
  localparam int IDX_W       = 12;
  localparam int LINE_SLOTS  = 32;
  localparam int GROUP_SLOTS = 8;
  localparam int SLOT_W      = $clog2(LINE_SLOTS);
  localparam int LINE_W      = IDX_W - SLOT_W;
  localparam int KCNT_W      = 2;
  localparam int MAX_ENTRIES = 1 << IDX_W;

  typedef enum logic {
    ACT_WRITE  = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

  typedef enum logic [KCNT_W-1:0] {
    KCNT_NONE  = 2'd0,
    KCNT_ONE   = 2'd1,
    KCNT_TWO   = 2'd2,
    KCNT_THREE = 2'd3
  } key_count_t;

  typedef struct packed {
    logic [CODE_W-1:0] key_a;
    logic [CODE_W-1:0] key_b;
    logic [CODE_W-1:0] key_c;
    key_count_t        key_count;
    logic [LINE_W-1:0] line;
    logic [SLOT_W-1:0] offset;
  } search_req_t;

endpackage

// File: sv/hclsrch_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered
// read data that holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps

module hclsrch_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/hclsrch_match.sv
// Match logic: compares one 32-code line with up to three keys under the
// per-group implicit-length rules and drops slots below the start offset.
// Depends on hclsrch_pkg.
`timescale 1ns / 1ps

module hclsrch_match
  import hclsrch_pkg::*;
#(
  parameter int EFF_SIZE = 4096
) (
  input  logic [CODE_W-1:0]     codes [LINE_SLOTS],
  input  search_req_t           req,
  output logic [LINE_SLOTS-1:0] mask
);

  localparam logic [IDX_W:0] SIZE_LIM = (IDX_W + 1)'(EFF_SIZE);

  logic [CODE_W-1:0]     line_z [LINE_SLOTS];
  logic [LINE_SLOTS-1:0] mask_a;
  logic [LINE_SLOTS-1:0] mask_b;
  logic [LINE_SLOTS-1:0] mask_c;
  logic [LINE_SLOTS-1:0] keep;

  function automatic logic [LINE_SLOTS-1:0] key_mask(
    input logic [CODE_W-1:0] line [LINE_SLOTS],
    input logic [CODE_W-1:0] key
  );
    logic [LINE_SLOTS-1:0] m;
    logic                  ended;
    m = '0;
    for (int g = 0; g < LINE_SLOTS; g += GROUP_SLOTS) begin
      ended = 1'b0;
      for (int i = 0; i < GROUP_SLOTS; i++) begin
        if (line[g + i] == '0) begin
          ended = 1'b1;
        end
        if (key == '0) begin
          m[g + i] = ended;
        end else begin
          m[g + i] = !ended && (line[g + i] == key);
        end
      end
    end
    return m;
  endfunction

  always_comb begin
    for (int i = 0; i < LINE_SLOTS; i++) begin
      if ({1'b0, req.line, SLOT_W'(i)} < SIZE_LIM) begin
        line_z[i] = codes[i];
      end else begin
        line_z[i] = '0;
      end
      keep[i] = (SLOT_W'(i) >= req.offset);
    end
  end

  always_comb begin
    mask_a = key_mask(line_z, req.key_a);
    mask_b = key_mask(line_z, req.key_b);
    mask_c = key_mask(line_z, req.key_c);
    case (req.key_count)
      KCNT_TWO:   mask = (mask_a | mask_b) & keep;
      KCNT_THREE: mask = (mask_a | mask_b | mask_c) & keep;
      default:    mask = mask_a & keep;
    endcase
  end

endmodule

// File: sv/hash_code_line_search_top.sv
// Hash code line search: one request per cycle unless the output is stalled; a
// request passes the s1, s2 and output registers on its way to out_valid. A
// search result waits in the output register and stalls the pipe, writes give
// no result. Code storage is 32 slot banks of registered-read RAM. rst_n
// (synchronous, active low) clears the pipeline valid bits only; table content
// is undefined until written. Depends on hclsrch_pkg, hclsrch_ram, hclsrch_match.
`timescale 1ns / 1ps

module hash_code_line_search_top
  import hclsrch_pkg::*;
#(
  parameter int TABLE_SIZE = 4096
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [IDX_W-1:0]  in_index,
  input  logic [CODE_W-1:0] in_write_code,
  input  logic [CODE_W-1:0] in_key_a,
  input  logic [CODE_W-1:0] in_key_b,
  input  logic [CODE_W-1:0] in_key_c,
  input  logic [KCNT_W-1:0] in_key_count,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_found,
  output logic [IDX_W-1:0]  out_position
);

  localparam int EFF_SIZE = (TABLE_SIZE > MAX_ENTRIES) ? MAX_ENTRIES : TABLE_SIZE;
  localparam int LINES    = (EFF_SIZE + LINE_SLOTS - 1) / LINE_SLOTS;
  localparam int RAM_AW   = (LINES > 1) ? $clog2(LINES) : 1;
  localparam logic [IDX_W:0] SIZE_LIM = (IDX_W + 1)'(EFF_SIZE);

  logic                  adv;
  logic                  wr_en;
  logic                  rd_en;
  logic [LINE_W-1:0]     in_line;
  logic [SLOT_W-1:0]     in_slot;
  logic [RAM_AW-1:0]     ram_addr;
  logic [CODE_W-1:0]     codes [LINE_SLOTS];
  logic [LINE_SLOTS-1:0] mask;
  search_req_t           in_req;

  logic                  s1_valid_r;
  search_req_t           s1_req_r;
  logic                  s2_valid_r;
  logic [LINE_SLOTS-1:0] s2_mask_r;
  logic [LINE_W-1:0]     s2_line_r;
  logic                  out_valid_r;
  logic                  out_found_r;
  logic [IDX_W-1:0]      out_position_r;
  logic                  found_nxt;
  logic [IDX_W-1:0]      position_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_line  = in_index[IDX_W-1:SLOT_W];
  assign in_slot  = in_index[SLOT_W-1:0];
  assign ram_addr = in_line[RAM_AW-1:0];
  assign wr_en    = in_valid && adv && (in_action == ACT_WRITE)
                    && ({1'b0, in_index} < SIZE_LIM);
  assign rd_en    = in_valid && adv && (in_action == ACT_SEARCH);

  always_comb begin
    in_req.key_a     = in_key_a;
    in_req.key_b     = in_key_b;
    in_req.key_c     = in_key_c;
    in_req.key_count = key_count_t'(in_key_count);
    in_req.line      = in_line;
    in_req.offset    = in_slot;
  end

  for (genvar i = 0; i < LINE_SLOTS; i++) begin : g_bank
    hclsrch_ram #(
      .WIDTH (CODE_W),
      .DEPTH (LINES),
      .ADDR_W(RAM_AW)
    ) u_bank (
      .clk  (clk),
      .we   (wr_en && (in_slot == SLOT_W'(i))),
      .waddr(ram_addr),
      .wdata(in_write_code),
      .re   (rd_en),
      .raddr(ram_addr),
      .rdata(codes[i])
    );
  end

  hclsrch_match #(
    .EFF_SIZE(EFF_SIZE)
  ) u_match (
    .codes(codes),
    .req  (s1_req_r),
    .mask (mask)
  );

  always_comb begin
    found_nxt    = 1'b0;
    position_nxt = '0;
    for (int i = LINE_SLOTS - 1; i >= 0; i--) begin
      if (s2_mask_r[i]) begin
        found_nxt    = 1'b1;
        position_nxt = {s2_line_r, SLOT_W'(i)};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= rd_en;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (rd_en) begin
        s1_req_r <= in_req;
      end
      s2_mask_r      <= mask;
      s2_line_r      <= s1_req_r.line;
      out_found_r    <= found_nxt;
      out_position_r <= position_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_position = out_position_r;

endmodule

// File: sv/hclsrch_chk.sv
// Port-level checker for hash_code_line_search_top, attached by bind.
// Depends on hclsrch_pkg.
`timescale 1ns / 1ps

module hclsrch_chk
  import hclsrch_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic [IDX_W-1:0]  out_position
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found) && $stable(out_position))
    else $error("result changed while stalled");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_position == '0)
    else $error("not-found result with non-zero position");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hash_code_line_search_top hclsrch_chk u_hclsrch_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_found   (out_found),
  .out_position(out_position)
);
